// File: rtl/debounced_edge_latch_bank_unit_macros.svh
// Assertion macros shared by the edge latch bank RTL.
`ifndef DEBOUNCED_EDGE_LATCH_BANK_UNIT_MACROS_SVH
`define DEBOUNCED_EDGE_LATCH_BANK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DELBU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delbu assertion failed");

// Next-cycle implication, checked outside reset.
`define DELBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delbu assertion failed");

`endif

// File: rtl/delbu_pkg.sv
// Package: command codes and the control bundle for the edge latch bank.
package delbu_pkg;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 3;
    localparam int MASK_W     = 8;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Per-item control sent from the sequencing stage to the channel bank
    typedef struct packed {
        logic                  edge_we;
        logic [CHAN_W-1:0]     edge_ch;
        logic                  read_en;
        logic                  clear;
        logic [TIME_W-1:0]     now_ms;
        logic [DEBOUNCE_W-1:0] debounce_ms;
    } bank_ctl_t;

endpackage

// File: rtl/delbu_if.sv
// Valid/ready channel interfaces for command items and result items.
interface delbu_req_if;
    logic                          valid;
    logic                          ready;
    logic [delbu_pkg::CMD_W-1:0]   cmd;
    logic [delbu_pkg::CHAN_W-1:0]  channel;
    logic                          clear_after;

    modport source (output valid, output cmd, output channel, output clear_after,
                    input ready);
    modport sink   (input valid, input cmd, input channel, input clear_after,
                    output ready);
endinterface

interface delbu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [delbu_pkg::MASK_W-1:0]  accepted_mask;
    logic [delbu_pkg::MASK_W-1:0]  ignored_mask;

    modport source (output valid, output accepted_mask, output ignored_mask,
                    input ready);
    modport sink   (input valid, input accepted_mask, input ignored_mask,
                    output ready);
endinterface

// File: rtl/delbu_chan_bank.sv
// Channel bank: pending flags, stamps, last accepted times and debounce compare.
module delbu_chan_bank #(
    parameter int CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  delbu_pkg::bank_ctl_t           ctl,
    output logic [delbu_pkg::MASK_W-1:0]   accepted_mask,
    output logic [delbu_pkg::MASK_W-1:0]   ignored_mask
);

    localparam int LOW_CH = (CHANNELS < delbu_pkg::MASK_W) ? CHANNELS : delbu_pkg::MASK_W;

    logic [CHANNELS-1:0]                 pending_reg;
    logic [delbu_pkg::TIME_W-1:0]        edge_time_reg [CHANNELS];
    logic [delbu_pkg::TIME_W-1:0]        last_reg      [CHANNELS];
    logic [CHANNELS-1:0]                 acc_full;
    logic [CHANNELS-1:0]                 ign_full;

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_chan
            logic [delbu_pkg::TIME_W-1:0] diff;
            logic                         past;
            logic                         hit;

            // Signed difference: negative never passes, else strictly above limit
            assign diff = edge_time_reg[gi] - last_reg[gi];
            assign past = !diff[delbu_pkg::TIME_W-1] &&
                          (diff[delbu_pkg::TIME_W-2:0] >
                           (delbu_pkg::TIME_W-1)'(ctl.debounce_ms));
            assign hit  = ctl.edge_we && (32'(ctl.edge_ch) == gi);
            assign acc_full[gi] = pending_reg[gi] && past;
            assign ign_full[gi] = pending_reg[gi] && !past;

            // Pending flag: set by an edge, cleared by a read with clear
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pending_reg[gi] <= 1'b0;
                end
                else if (hit)
                begin
                    pending_reg[gi] <= 1'b1;
                end
                else if (ctl.read_en && ctl.clear)
                begin
                    pending_reg[gi] <= 1'b0;
                end
            end

            // Stamps; reset value is part of the behavior
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    edge_time_reg[gi] <= '0;
                    last_reg[gi]      <= '0;
                end
                else
                begin
                    if (hit)
                    begin
                        edge_time_reg[gi] <= ctl.now_ms;
                    end
                    if (ctl.read_en && acc_full[gi])
                    begin
                        last_reg[gi] <= edge_time_reg[gi];
                    end
                end
            end
        end
    endgenerate

    // Channels above the output width are kept but not reported
    assign accepted_mask = delbu_pkg::MASK_W'(acc_full[LOW_CH-1:0]);
    assign ignored_mask  = delbu_pkg::MASK_W'(ign_full[LOW_CH-1:0]);

endmodule

// File: rtl/debounced_edge_latch_bank_unit.sv
// Top level: input register, command sequencing, time base and result register.
//
//   channel   dir   handshake      payload
//   req       in    valid/ready    cmd, channel, clear_after
//   rsp       out   valid/ready    accepted_mask, ignored_mask
//   cfg       in    cfg_we         cfg_wdata (debounce_ms)
//
// One item per cycle sustained while no read stalls. An accepted item waits in the
// input register and is evaluated there; a read's masks go to the result register.
// Latency comes from the input and result registers around the per-channel compares.
// A read waits in the input register only while the result register is full
// and not taken; ticks and edges never wait on the result side.
// Reset (rst_n low, asynchronous) clears time, flags, stamps; debounce_ms = 50.
`include "debounced_edge_latch_bank_unit_macros.svh"

module debounced_edge_latch_bank_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    delbu_req_if.sink                          req,
    delbu_rsp_if.source                        rsp,
    input  logic                               cfg_we,
    input  logic [delbu_pkg::DEBOUNCE_W-1:0]   cfg_wdata
);

    logic                                s1_valid_reg;
    delbu_pkg::cmd_t                     s1_cmd_reg;
    logic [delbu_pkg::CHAN_W-1:0]        s1_ch_reg;
    logic                                s1_clr_reg;
    logic [delbu_pkg::TIME_W-1:0]        now_ms_reg;
    logic [delbu_pkg::DEBOUNCE_W-1:0]    debounce_reg;
    logic                                out_valid_reg;
    logic [delbu_pkg::MASK_W-1:0]        acc_reg;
    logic [delbu_pkg::MASK_W-1:0]        ign_reg;

    logic                                out_free;
    logic                                s1_go;
    logic                                is_tick;
    logic                                is_edge;
    logic                                is_read;
    delbu_pkg::bank_ctl_t                ctl;
    logic [delbu_pkg::MASK_W-1:0]        acc_mask;
    logic [delbu_pkg::MASK_W-1:0]        ign_mask;

    // Stage control
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_go     = s1_valid_reg && (!is_read || out_free);
    assign req.ready = !s1_valid_reg || s1_go;

    // Command decode
    always_comb
    begin
        is_tick = 1'b0;
        is_edge = 1'b0;
        is_read = 1'b0;
        unique case (s1_cmd_reg)
            delbu_pkg::CMD_TICK: is_tick = 1'b1;
            delbu_pkg::CMD_EDGE: is_edge = 1'b1;
            delbu_pkg::CMD_READ: is_read = 1'b1;
            default:             ;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg <= delbu_pkg::cmd_t'(req.cmd);
            s1_ch_reg  <= req.channel;
            s1_clr_reg <= req.clear_after;
        end
    end

    // Time base and debounce register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg   <= '0;
            debounce_reg <= delbu_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            if (s1_go && is_tick)
            begin
                now_ms_reg <= now_ms_reg + 32'd1;
            end
            if (cfg_we)
            begin
                debounce_reg <= cfg_wdata;
            end
        end
    end

    // Bank control for the item being evaluated
    always_comb
    begin
        ctl.edge_we     = s1_go && is_edge && (32'(s1_ch_reg) < CHANNELS);
        ctl.edge_ch     = s1_ch_reg;
        ctl.read_en     = s1_go && is_read;
        ctl.clear       = s1_clr_reg;
        ctl.now_ms      = now_ms_reg;
        ctl.debounce_ms = debounce_reg;
    end

    delbu_chan_bank #(
        .CHANNELS (CHANNELS)
    ) u_bank (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .accepted_mask (acc_mask),
        .ignored_mask  (ign_mask)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.read_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read_en)
        begin
            acc_reg <= acc_mask;
            ign_reg <= ign_mask;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted_mask = acc_reg;
    assign rsp.ignored_mask  = ign_reg;

    // Checks
    `DELBU_ASSERT_NEXT(a_read_gives_result, clk, rst_n, ctl.read_en, out_valid_reg)
    `DELBU_ASSERT_NEXT(a_tick_advances, clk, rst_n, s1_go && is_tick,
        now_ms_reg == $past(now_ms_reg) + 32'd1)
    `DELBU_ASSERT_NOW(a_stall_only_on_full_out, clk, rst_n, s1_valid_reg && !s1_go,
        is_read && out_valid_reg && !rsp.ready)

endmodule
